// ----- hdl/ccg_pkg.sv -----
// Shared types, widths, register codes and reset values for the crossing count trigger gate.
`timescale 1ns / 1ps

package ccg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 15;
	localparam int TOTAL_W    = 19;
	localparam int SPAN_W     = 7;
	localparam int FRAME_W    = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	localparam int DEF_MAX_SPAN   = 64;
	localparam int DEF_MAX_BUFFER = 4096;
	localparam int QUEUE_DEPTH    = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEVEL = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_NEEDED = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SPAN   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SPAN  = CFG_IDX_W'(5);

	localparam logic [LEVEL_W-1:0] RST_OPEN_LEVEL  = LEVEL_W'(3277);
	localparam logic [LEVEL_W-1:0] RST_CLOSE_LEVEL = LEVEL_W'(1638);
	localparam logic [TOTAL_W-1:0] RST_OPEN_NEEDED = TOTAL_W'(10);
	localparam logic [TOTAL_W-1:0] RST_CLOSE_LIMIT = TOTAL_W'(5);
	localparam logic [SPAN_W-1:0]  RST_OPEN_SPAN   = SPAN_W'(8);
	localparam logic [SPAN_W-1:0]  RST_CLOSE_SPAN  = SPAN_W'(16);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       ends_buffer;
	} in_item_t;

	typedef struct packed {
		logic               gate_open;
		logic [TOTAL_W-1:0] open_total;
		logic [TOTAL_W-1:0] close_total;
		logic [FRAME_W-1:0] frames_seen;
	} out_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] open_needed;
		logic [TOTAL_W-1:0] close_limit;
		logic [SPAN_W-1:0]  open_span;
		logic [SPAN_W-1:0]  close_span;
	} gate_cfg_t;

	typedef struct packed {
		logic open_ring;
		logic close_ring;
	} ring_clr_t;

	// Saturation point of one per-buffer crossing count.
	function automatic int cnt_cap(input int max_buffer);
		return 2 * (max_buffer - 1);
	endfunction

endpackage

// ----- hdl/ccg_front.sv -----
// Front end: accepts samples, counts level crossings per buffer and emits one record per buffer.
`timescale 1ns / 1ps

module ccg_front #(
	parameter int  MaxBuffer = ccg_pkg::DEF_MAX_BUFFER,
	localparam int CntW      = $clog2(ccg_pkg::cnt_cap(MaxBuffer) + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  ccg_pkg::in_item_t              sample_item,
	input  logic [ccg_pkg::LEVEL_W-1:0]    open_level,
	input  logic [ccg_pkg::LEVEL_W-1:0]    close_level,
	output logic                           rec_push,
	input  logic                           rec_ready,
	output logic [CntW-1:0]                rec_open_cnt,
	output logic [CntW-1:0]                rec_close_cnt,
	output logic [ccg_pkg::FRAME_W-1:0]    rec_frame
);
	import ccg_pkg::*;

	localparam int CntW1 = CntW + 1;
	localparam logic [CntW1-1:0] Cap = CntW1'(cnt_cap(MaxBuffer));

	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       prev_v_q;
	logic [CntW-1:0]            ocnt_q;
	logic [CntW-1:0]            ccnt_q;
	logic [FRAME_W-1:0]         frame_q;

	logic                       accept;
	logic [CntW-1:0]            ocnt_n;
	logic [CntW-1:0]            ccnt_n;
	logic [FRAME_W-1:0]         frame_n;

	// Strict crossings of +level and -level between two neighboring samples.
	function automatic logic [1:0] pair_cross(input logic signed [SAMPLE_W:0] a,
			input logic signed [SAMPLE_W:0] b, input logic [LEVEL_W-1:0] level);
		logic signed [SAMPLE_W:0] lp;
		logic signed [SAMPLE_W:0] ln;
		logic                     up;
		logic                     dn;
		lp = signed'({2'b00, level});
		ln = -lp;
		up = ((a < lp) && (lp < b)) || ((b < lp) && (lp < a));
		dn = ((a < ln) && (ln < b)) || ((b < ln) && (ln < a));
		return {1'b0, up} + {1'b0, dn};
	endfunction

	function automatic logic [CntW-1:0] add_sat(input logic [CntW-1:0] c,
			input logic [1:0] n);
		logic [CntW1-1:0] s;
		s = {1'b0, c} + CntW1'(n);
		if (s > Cap) begin
			s = Cap;
		end
		return s[CntW-1:0];
	endfunction

	assign accept       = sample_valid && rec_ready;
	assign sample_stall = !rec_ready;
	assign frame_n      = frame_q + FRAME_W'(1);

	always_comb begin
		logic signed [SAMPLE_W:0] a;
		logic signed [SAMPLE_W:0] b;
		a = {prev_q[SAMPLE_W-1], prev_q};
		b = {sample_item.sample[SAMPLE_W-1], sample_item.sample};
		ocnt_n = ocnt_q;
		ccnt_n = ccnt_q;
		if (prev_v_q) begin
			ocnt_n = add_sat(ocnt_q, pair_cross(a, b, open_level));
			ccnt_n = add_sat(ccnt_q, pair_cross(a, b, close_level));
		end
	end

	assign rec_push      = accept && sample_item.ends_buffer;
	assign rec_open_cnt  = ocnt_n;
	assign rec_close_cnt = ccnt_n;
	assign rec_frame     = frame_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			prev_v_q <= 1'b0;
			ocnt_q   <= '0;
			ccnt_q   <= '0;
			frame_q  <= '0;
		end else if (accept) begin
			frame_q <= frame_n;
			prev_q  <= sample_item.sample;
			if (sample_item.ends_buffer) begin
				prev_v_q <= 1'b0;
				ocnt_q   <= '0;
				ccnt_q   <= '0;
			end else begin
				prev_v_q <= 1'b1;
				ocnt_q   <= ocnt_n;
				ccnt_q   <= ccnt_n;
			end
		end
	end

endmodule

// ----- hdl/ccg_queue.sv -----
// Short first-in first-out queue for buffer records between the front and back ends.
`timescale 1ns / 1ps

module ccg_queue #(
	parameter int  Width = 8,
	parameter int  Depth = ccg_pkg::QUEUE_DEPTH,
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1,
	localparam int CW    = $clog2(Depth + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [Width-1:0] pop_data
);
	import ccg_pkg::*;

	logic [Width-1:0] slot_q [Depth];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign push_ready = (cnt_q != CW'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign push_ok    = push && push_ready;
	assign pop_ok     = pop && pop_valid;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop_ok) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth)) else $error("queue count above depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("queue count missed a push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && !push_ok) |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("queue count missed a pop");
`endif

endmodule

// ----- hdl/ccg_ring.sv -----
// Window ring: stores per-buffer counts in a memory and keeps their running sum.
`timescale 1ns / 1ps

module ccg_ring #(
	parameter int  MaxSpan   = ccg_pkg::DEF_MAX_SPAN,
	parameter int  MaxBuffer = ccg_pkg::DEF_MAX_BUFFER,
	localparam int CntW      = $clog2(ccg_pkg::cnt_cap(MaxBuffer) + 1),
	localparam int SumW      = $clog2(MaxSpan * ccg_pkg::cnt_cap(MaxBuffer) + 1),
	localparam int PosW      = (MaxSpan > 1) ? $clog2(MaxSpan) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic [ccg_pkg::SPAN_W-1:0]  span,
	input  logic                        load,
	input  logic [CntW-1:0]             load_val,
	input  logic                        commit,
	output logic [SumW-1:0]             sum_next
);
	import ccg_pkg::*;

	localparam int CmpW = PosW + SPAN_W + 1;
	localparam logic [SumW-1:0] SumMax = SumW'(MaxSpan * cnt_cap(MaxBuffer));

	logic [CntW-1:0] mem [MaxSpan];
	logic [PosW-1:0] pos_q;
	logic            live_q;
	logic [SumW-1:0] sum_q;
	logic [PosW-1:0] pos_s1;
	logic [CntW-1:0] val_s1;
	logic [CntW-1:0] rd_q;
	logic            rdv_q;

	logic [CmpW-1:0] span_used;
	logic [CmpW-1:0] pos_inc;
	logic            wrap;
	logic            fwd;
	logic [CntW-1:0] old_val;

	always_comb begin
		span_used = CmpW'(span);
		if (span_used == '0) begin
			span_used = CmpW'(1);
		end else if (span_used > CmpW'(MaxSpan)) begin
			span_used = CmpW'(MaxSpan);
		end
	end

	assign pos_inc  = CmpW'(pos_q) + CmpW'(1);
	assign wrap     = (pos_inc >= span_used);
	// A record still in the commit stage writes the slot being read right now.
	assign fwd      = commit && (pos_s1 == pos_q);
	assign old_val  = rdv_q ? rd_q : '0;
	assign sum_next = sum_q - SumW'(old_val) + SumW'(val_s1);

	always_ff @(posedge clk) begin
		if (commit) begin
			mem[pos_s1] <= val_s1;
		end
		if (load) begin
			pos_s1 <= pos_q;
			val_s1 <= load_val;
			rd_q   <= fwd ? val_s1 : mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			live_q <= 1'b0;
			sum_q  <= '0;
			rdv_q  <= 1'b0;
		end else if (clr) begin
			pos_q  <= '0;
			live_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			if (commit) begin
				sum_q <= sum_next;
			end
			if (load) begin
				rdv_q <= fwd || live_q;
				if (wrap) begin
					pos_q  <= '0;
					live_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[PosW-1:0];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(pos_q) < span_used) else $error("ring position outside span");
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SumMax) else $error("ring sum above window bound");
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(load && fwd && !clr) |=> rdv_q) else $error("forwarded slot not marked live");
`endif

endmodule

// ----- hdl/ccg_back.sv -----
// Back end: pushes buffer records into both window rings, updates the gate, holds the result.
`timescale 1ns / 1ps

module ccg_back #(
	parameter int  MaxSpan   = ccg_pkg::DEF_MAX_SPAN,
	parameter int  MaxBuffer = ccg_pkg::DEF_MAX_BUFFER,
	localparam int CntW      = $clog2(ccg_pkg::cnt_cap(MaxBuffer) + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccg_pkg::gate_cfg_t          cfg,
	input  ccg_pkg::ring_clr_t          clr,
	input  logic                        rec_valid,
	output logic                        rec_pop,
	input  logic [CntW-1:0]             rec_open_cnt,
	input  logic [CntW-1:0]             rec_close_cnt,
	input  logic [ccg_pkg::FRAME_W-1:0] rec_frame,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ccg_pkg::out_item_t          result_item
);
	import ccg_pkg::*;

	localparam int SumW = $clog2(MaxSpan * cnt_cap(MaxBuffer) + 1);
	localparam int TotW = (SumW > TOTAL_W) ? SumW : TOTAL_W;

	logic               s1_v_q;
	logic [FRAME_W-1:0] frame_s1;
	logic               gate_q;
	logic               out_v_q;
	out_item_t          out_q;

	logic               s1_adv;
	logic               commit;
	logic [SumW-1:0]    osum_n;
	logic [SumW-1:0]    csum_n;
	logic [TotW-1:0]    osum_x;
	logic [TotW-1:0]    csum_x;
	logic               open_hit;
	logic               gate_n;

	assign s1_adv  = !out_v_q || !result_stall;
	assign commit  = s1_v_q && s1_adv;
	assign rec_pop = rec_valid && (!s1_v_q || s1_adv);

	ccg_ring #(.MaxSpan(MaxSpan), .MaxBuffer(MaxBuffer)) u_open_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr.open_ring),
		.span     (cfg.open_span),
		.load     (rec_pop),
		.load_val (rec_open_cnt),
		.commit   (commit),
		.sum_next (osum_n)
	);

	ccg_ring #(.MaxSpan(MaxSpan), .MaxBuffer(MaxBuffer)) u_close_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr.close_ring),
		.span     (cfg.close_span),
		.load     (rec_pop),
		.load_val (rec_close_cnt),
		.commit   (commit),
		.sum_next (csum_n)
	);

	assign osum_x   = TotW'(osum_n);
	assign csum_x   = TotW'(csum_n);
	assign open_hit = osum_x >= TotW'(cfg.open_needed);

	// A closed gate follows the open check; an open gate that fails it closes
	// only once the close window has gone quiet enough.
	always_comb begin
		gate_n = gate_q;
		if (!gate_q) begin
			gate_n = open_hit;
		end else if (!open_hit) begin
			gate_n = !(csum_x <= TotW'(cfg.close_limit));
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			frame_s1 <= rec_frame;
		end
		if (commit) begin
			out_q.gate_open   <= gate_n;
			out_q.open_total  <= osum_x[TOTAL_W-1:0];
			out_q.close_total <= csum_x[TOTAL_W-1:0];
			out_q.frames_seen <= frame_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			gate_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rec_pop) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= s1_v_q;
			end
			if (commit) begin
				gate_q <= gate_n;
			end
		end
	end

	assign result_valid = out_v_q;
	assign result_item  = out_q;

endmodule

// ----- hdl/crossing_count_trigger_gate_unit.sv -----
// Top level of the crossing count trigger gate: configuration registers and the two ends.
// A result becomes valid after its record passes the queue, the back end stage and its register.
// Throughput: one sample per cycle while the record queue has room, also in one-sample buffers;
// ring memories are read one buffer ahead of the sum update, forwarding when both hit one slot.
// Samples that do not end a buffer give no result and only wait when the record queue is full.
// Reset (asynchronous, active low) clears all control state and loads the register defaults;
// ring memories are not swept, unwritten slots read as zero through a wrap flag per ring.
`timescale 1ns / 1ps

module crossing_count_trigger_gate_unit #(
	parameter int MaxSpan   = ccg_pkg::DEF_MAX_SPAN,
	parameter int MaxBuffer = ccg_pkg::DEF_MAX_BUFFER
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  ccg_pkg::in_item_t              sample_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ccg_pkg::out_item_t             result_item,
	input  logic                           cfg_we,
	input  logic [ccg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ccg_pkg::*;

	// Width of one per-buffer crossing count and of one queued buffer record.
	localparam int CntW = $clog2(cnt_cap(MaxBuffer) + 1);
	localparam int RecW = 2 * CntW + FRAME_W;

	// Configuration registers. The span registers also clear their ring,
	// which happens in the ring itself at the same clock edge as the write.
	logic [LEVEL_W-1:0] open_level_q;
	logic [LEVEL_W-1:0] close_level_q;
	gate_cfg_t          cfg_q;
	ring_clr_t          clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_level_q      <= RST_OPEN_LEVEL;
			close_level_q     <= RST_CLOSE_LEVEL;
			cfg_q.open_needed <= RST_OPEN_NEEDED;
			cfg_q.close_limit <= RST_CLOSE_LIMIT;
			cfg_q.open_span   <= RST_OPEN_SPAN;
			cfg_q.close_span  <= RST_CLOSE_SPAN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_LEVEL:  open_level_q      <= cfg_data[LEVEL_W-1:0];
				CFG_CLOSE_LEVEL: close_level_q     <= cfg_data[LEVEL_W-1:0];
				CFG_OPEN_NEEDED: cfg_q.open_needed <= cfg_data[TOTAL_W-1:0];
				CFG_CLOSE_LIMIT: cfg_q.close_limit <= cfg_data[TOTAL_W-1:0];
				CFG_OPEN_SPAN:   cfg_q.open_span   <= cfg_data[SPAN_W-1:0];
				CFG_CLOSE_SPAN:  cfg_q.close_span  <= cfg_data[SPAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign clr.open_ring  = cfg_we && (cfg_index == CFG_OPEN_SPAN);
	assign clr.close_ring = cfg_we && (cfg_index == CFG_CLOSE_SPAN);

	// Front end to queue: one record per finished buffer.
	logic               push;
	logic               push_ready;
	logic [CntW-1:0]    f_open_cnt;
	logic [CntW-1:0]    f_close_cnt;
	logic [FRAME_W-1:0] f_frame;

	ccg_front #(.MaxBuffer(MaxBuffer)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_item   (sample_item),
		.open_level    (open_level_q),
		.close_level   (close_level_q),
		.rec_push      (push),
		.rec_ready     (push_ready),
		.rec_open_cnt  (f_open_cnt),
		.rec_close_cnt (f_close_cnt),
		.rec_frame     (f_frame)
	);

	// The queue lets the sample side keep running while a result waits.
	logic            q_valid;
	logic            q_pop;
	logic [RecW-1:0] q_data;

	ccg_queue #(.Width(RecW), .Depth(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  ({f_open_cnt, f_close_cnt, f_frame}),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	// Back end: ring updates, gate decision and the result register.
	ccg_back #(.MaxSpan(MaxSpan), .MaxBuffer(MaxBuffer)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.clr           (clr),
		.rec_valid     (q_valid),
		.rec_pop       (q_pop),
		.rec_open_cnt  (q_data[RecW-1 -: CntW]),
		.rec_close_cnt (q_data[FRAME_W +: CntW]),
		.rec_frame     (q_data[FRAME_W-1:0]),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_item   (result_item)
	);

endmodule
